>>> hw/rtl/task_trigger_scheduler_assert.svh
// ----------------------------------------------------------------------------
// Task trigger scheduler assertion macros
// Concurrent assertion helpers, clocked on the rising edge and disabled while
// the asynchronous active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef TASK_TRIGGER_SCHEDULER_ASSERT_SVH
`define TASK_TRIGGER_SCHEDULER_ASSERT_SVH

// The property must hold at every rising clock edge out of reset.
`define TTS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define TTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/tts_pkg.sv
// ----------------------------------------------------------------------------
// Task trigger scheduler package
// Beat types, trigger cause codes and per-task update record.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int unsigned TaskIdxW  = 3;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned TaskSpace = 2 ** TaskIdxW;

  typedef enum logic [1:0] {
    CauseNone     = 2'd0,
    CauseSingle   = 2'd1,
    CauseInterval = 2'd2
  } cause_e;

  typedef struct packed {
    logic [TaskIdxW-1:0] task_index;
    logic                resource_running;
    logic                task_available;
    logic                single_level;
    logic [TimeW-1:0]    interval_ms;
    logic [TimeW-1:0]    now_ms;
  } in_beat_t;

  typedef struct packed {
    logic [TaskIdxW-1:0] result_task;
    cause_e              trigger_cause;
  } out_beat_t;

  typedef struct packed {
    logic             single_prev;
    logic [TimeW-1:0] interval_start;
  } task_state_t;

  typedef struct packed {
    logic             prev_we;
    logic             single_prev;
    logic             start_we;
    logic [TimeW-1:0] interval_start;
  } task_update_t;

endpackage

>>> hw/rtl/tts_stream_if.sv
// ----------------------------------------------------------------------------
// Task trigger scheduler stream interface
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface tts_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (
    output valid,
    output payload,
    input  ready
  );

  modport sink (
    input  valid,
    input  payload,
    output ready
  );

endinterface

>>> hw/rtl/tts_trigger_eval.sv
// ----------------------------------------------------------------------------
// Task trigger evaluator
// Decides the trigger cause for one tick and the new state of its task.
// ----------------------------------------------------------------------------
module tts_trigger_eval (
  input  tts_pkg::in_beat_t     beat_i,
  input  logic                  in_range_i,
  input  tts_pkg::task_state_t  state_i,
  output tts_pkg::cause_e       cause_o,
  output tts_pkg::task_update_t update_o
);

  logic [tts_pkg::TimeW-1:0] elapsed;

  assign elapsed = beat_i.now_ms - state_i.interval_start;

  always_comb begin
    cause_o                 = tts_pkg::CauseNone;
    update_o.prev_we        = 1'b0;
    update_o.single_prev    = 1'b0;
    update_o.start_we       = 1'b0;
    update_o.interval_start = beat_i.now_ms;
    if (in_range_i && beat_i.resource_running) begin
      if (!beat_i.task_available) begin
        update_o.prev_we  = 1'b1;
        update_o.start_we = 1'b1;
      end else begin
        update_o.prev_we     = 1'b1;
        update_o.single_prev = beat_i.single_level;
        if (beat_i.single_level) begin
          update_o.start_we = 1'b1;
          if (!state_i.single_prev) begin
            cause_o = tts_pkg::CauseSingle;
          end
        end else if ((beat_i.interval_ms != '0) && (elapsed >= beat_i.interval_ms)) begin
          cause_o           = tts_pkg::CauseInterval;
          update_o.start_we = 1'b1;
        end
      end
    end
  end

endmodule

>>> hw/rtl/task_trigger_scheduler.sv
// ----------------------------------------------------------------------------
// Task trigger scheduler
// Per-task SINGLE edge and cyclic interval trigger unit.
// ----------------------------------------------------------------------------
// Each input beat is one scheduler tick for one task and yields exactly one
// result beat carrying the task index and the trigger cause. A new tick is
// taken in every cycle while the output is not stalled. The result beat is
// presented once the tick has passed the input register and the single
// read-modify-write of the per-task state registers into the result register.
// Task state is cleared by reset, and ticks for an index at or beyond
// MAX_TASKS leave the state untouched and report no trigger.
module task_trigger_scheduler #(
  parameter int unsigned MAX_TASKS = 8
) (
  input logic              clk_i,
  input logic              rst_ni,
  tts_stream_if.sink       in_i,
  tts_stream_if.source     out_o
);

  `include "task_trigger_scheduler_assert.svh"

  localparam int unsigned NumSlots =
    (MAX_TASKS < tts_pkg::TaskSpace) ? MAX_TASKS : tts_pkg::TaskSpace;
  localparam int unsigned SlotW = (NumSlots > 1) ? $clog2(NumSlots) : 1;

  logic                      s1_valid_q;
  tts_pkg::in_beat_t         s1_beat_q;
  logic                      out_valid_q;
  tts_pkg::out_beat_t        out_beat_q;

  logic                      single_prev_q [NumSlots];
  logic [tts_pkg::TimeW-1:0] interval_start_q [NumSlots];

  logic                      out_free;
  logic                      s1_advance;
  logic                      in_range;
  logic [SlotW-1:0]          slot;
  tts_pkg::task_state_t      cur_state;
  tts_pkg::cause_e           cause;
  tts_pkg::task_update_t     update;

  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_advance = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;

  assign in_range = 32'(s1_beat_q.task_index) < MAX_TASKS;
  assign slot     = SlotW'(s1_beat_q.task_index);

  always_comb begin
    cur_state.single_prev    = 1'b0;
    cur_state.interval_start = '0;
    if (in_range) begin
      cur_state.single_prev    = single_prev_q[slot];
      cur_state.interval_start = interval_start_q[slot];
    end
  end

  tts_trigger_eval u_eval (
    .beat_i     (s1_beat_q),
    .in_range_i (in_range),
    .state_i    (cur_state),
    .cause_o    (cause),
    .update_o   (update)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_beat_q <= in_i.payload;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      out_beat_q.result_task   <= s1_beat_q.task_index;
      out_beat_q.trigger_cause <= cause;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumSlots; i++) begin
        single_prev_q[i]    <= 1'b0;
        interval_start_q[i] <= '0;
      end
    end else if (s1_advance) begin
      if (update.prev_we) begin
        single_prev_q[slot] <= update.single_prev;
      end
      if (update.start_we) begin
        interval_start_q[slot] <= update.interval_start;
      end
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_beat_q;

  `TTS_ASSERT_NEXT(a_advance_fills_output, clk_i, rst_ni, s1_advance, out_valid_q,
                   "Advanced tick did not reach the output register.")
  `TTS_ASSERT(a_trigger_needs_live_task, clk_i, rst_ni,
              !s1_valid_q || (cause == tts_pkg::CauseNone) ||
              (in_range && s1_beat_q.resource_running && s1_beat_q.task_available),
              "Trigger reported for an ignored or unavailable task.")
  `TTS_ASSERT_NEXT(a_single_sets_history, clk_i, rst_ni,
                   s1_advance && (cause == tts_pkg::CauseSingle),
                   single_prev_q[$past(slot)],
                   "SINGLE trigger did not record the high level.")

endmodule

>>> tb/sv/task_trigger_scheduler_tb.sv
// ----------------------------------------------------------------------------
// Task trigger scheduler testbench
// Drives scheduler ticks into the block through its valid/ready input channel
// and predicts every result beat from a private copy of the per-task SINGLE
// history and interval start times. Directed ticks cover the edge, hold,
// unavailable, disabled-interval and wrap-around cases; random ticks follow
// a slowly advancing millisecond clock, mixed with occasional noise. Both
// channels idle at random.
// ----------------------------------------------------------------------------
module task_trigger_scheduler_tb;

  localparam int unsigned MaxTasks = 8;
  localparam int unsigned NumRandomTicks = 800;

  class trigger_scoreboard;
    tts_pkg::out_beat_t        expected_q[$];
    logic                      single_prev[tts_pkg::TaskSpace];
    logic [tts_pkg::TimeW-1:0] interval_start[tts_pkg::TaskSpace];
    int unsigned               errors;
    int unsigned               ticks;
    int unsigned               single_hits;
    int unsigned               interval_hits;

    function new();
      for (int i = 0; i < tts_pkg::TaskSpace; i++) begin
        single_prev[i] = 1'b0;
        interval_start[i] = '0;
      end
      errors = 0;
      ticks = 0;
      single_hits = 0;
      interval_hits = 0;
    endfunction

    function void note_tick(tts_pkg::in_beat_t t);
      tts_pkg::out_beat_t        r;
      logic [tts_pkg::TimeW-1:0] elapsed;
      int unsigned               idx;
      idx = 32'(t.task_index);
      r.result_task = t.task_index;
      r.trigger_cause = tts_pkg::CauseNone;
      if (t.resource_running && idx < MaxTasks) begin
        if (!t.task_available) begin
          single_prev[idx] = 1'b0;
          interval_start[idx] = t.now_ms;
        end else begin
          if (!single_prev[idx] && t.single_level) begin
            r.trigger_cause = tts_pkg::CauseSingle;
          end
          single_prev[idx] = t.single_level;
          if (t.single_level) begin
            interval_start[idx] = t.now_ms;
          end else if (t.interval_ms != '0) begin
            elapsed = t.now_ms - interval_start[idx];
            if (elapsed >= t.interval_ms) begin
              r.trigger_cause = tts_pkg::CauseInterval;
              interval_start[idx] = t.now_ms;
            end
          end
        end
      end
      if (r.trigger_cause == tts_pkg::CauseSingle) single_hits++;
      if (r.trigger_cause == tts_pkg::CauseInterval) interval_hits++;
      ticks++;
      expected_q.push_back(r);
    endfunction

    function void check_result(tts_pkg::out_beat_t got);
      tts_pkg::out_beat_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result beat with nothing expected: task %0d cause %0d",
                 $time, got.result_task, got.trigger_cause);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got.result_task !== want.result_task) begin
          $display("%0t: result_task mismatch: expected %0d actual %0d",
                   $time, want.result_task, got.result_task);
          errors++;
        end
        if (got.trigger_cause !== want.trigger_cause) begin
          $display("%0t: trigger_cause mismatch on task %0d: expected %0d actual %0d",
                   $time, want.result_task, want.trigger_cause, got.trigger_cause);
          errors++;
        end
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  tts_stream_if #(.payload_t(tts_pkg::in_beat_t))  in_if ();
  tts_stream_if #(.payload_t(tts_pkg::out_beat_t)) out_if ();

  task_trigger_scheduler #(
    .MAX_TASKS(MaxTasks)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  trigger_scoreboard         sb;
  int unsigned               burst_left;
  int unsigned               rx_cycle;
  logic [tts_pkg::TimeW-1:0] sim_ms;
  logic                      level[tts_pkg::TaskSpace];
  logic [tts_pkg::TimeW-1:0] period[tts_pkg::TaskSpace];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("task_trigger_scheduler_tb failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      sb.check_result(out_if.payload);
    end
    case ((rx_cycle / 64) % 4)
      0: out_if.ready <= 1'b1;
      1: out_if.ready <= ($urandom_range(0, 3) != 0);
      2: out_if.ready <= ((rx_cycle % 5) != 0);
      default: out_if.ready <= ((rx_cycle % 16) < 3);
    endcase
    rx_cycle <= rx_cycle + 1;
  end

  function automatic tts_pkg::in_beat_t make_tick(int unsigned idx, logic run, logic avail,
                                                  logic single,
                                                  logic [tts_pkg::TimeW-1:0] interval,
                                                  logic [tts_pkg::TimeW-1:0] now);
    tts_pkg::in_beat_t t;
    t.task_index = idx[tts_pkg::TaskIdxW-1:0];
    t.resource_running = run;
    t.task_available = avail;
    t.single_level = single;
    t.interval_ms = interval;
    t.now_ms = now;
    return t;
  endfunction

  function automatic logic [tts_pkg::TimeW-1:0] pick_period();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return $urandom;
      default: return $urandom_range(1, 60);
    endcase
  endfunction

  function automatic tts_pkg::in_beat_t next_random_tick();
    tts_pkg::in_beat_t t;
    int unsigned       idx;
    idx = $urandom_range(0, MaxTasks - 1);
    if ($urandom_range(0, 99) < 8) begin
      t = make_tick(idx, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), $urandom, $urandom);
    end else begin
      sim_ms = sim_ms + $urandom_range(0, 6);
      if ($urandom_range(0, 6) == 0) level[idx] = ~level[idx];
      if ($urandom_range(0, 29) == 0) period[idx] = pick_period();
      t = make_tick(idx, $urandom_range(0, 19) != 0, $urandom_range(0, 11) != 0,
                    level[idx], period[idx], sim_ms);
    end
    return t;
  endfunction

  task automatic send_tick(tts_pkg::in_beat_t t);
    in_if.valid <= 1'b1;
    in_if.payload <= t;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_tick(t);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end else begin
      burst_left--;
    end
  endtask

  initial begin
    sb = new();
    burst_left = 0;
    rst_ni <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.payload <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Resource stopped, then edge, hold and release of SINGLE.
    send_tick(make_tick(0, 1'b0, 1'b1, 1'b1, 32'd5, 32'd100));
    send_tick(make_tick(1, 1'b1, 1'b1, 1'b1, 32'd0, 32'd10));
    send_tick(make_tick(1, 1'b1, 1'b1, 1'b1, 32'd0, 32'd20));
    send_tick(make_tick(1, 1'b1, 1'b1, 1'b0, 32'd0, 32'd30));
    send_tick(make_tick(1, 1'b1, 1'b1, 1'b1, 32'd10, 32'd40));
    send_tick(make_tick(1, 1'b1, 1'b0, 1'b1, 32'd10, 32'd41));
    send_tick(make_tick(1, 1'b1, 1'b1, 1'b1, 32'd10, 32'd42));
    // Cyclic interval from the reset start time.
    send_tick(make_tick(2, 1'b1, 1'b1, 1'b0, 32'd100, 32'd50));
    send_tick(make_tick(2, 1'b1, 1'b1, 1'b0, 32'd100, 32'd100));
    send_tick(make_tick(2, 1'b1, 1'b1, 1'b0, 32'd100, 32'd199));
    send_tick(make_tick(2, 1'b1, 1'b1, 1'b0, 32'd100, 32'd200));
    send_tick(make_tick(2, 1'b1, 1'b1, 1'b0, 32'd0, 32'd9000));
    // Elapsed time across the wrap of the millisecond clock.
    send_tick(make_tick(3, 1'b1, 1'b0, 1'b0, 32'd0, 32'hFFFF_FFF0));
    send_tick(make_tick(3, 1'b1, 1'b1, 1'b0, 32'h20, 32'h0000_000F));
    send_tick(make_tick(3, 1'b1, 1'b1, 1'b0, 32'h20, 32'h0000_0010));
    // Field extremes.
    send_tick(make_tick(4, 1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_tick(make_tick(4, 1'b1, 1'b1, 1'b0, 32'd1, 32'hFFFF_FFFF));
    send_tick(make_tick(7, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_tick(make_tick(7, 1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000));
    send_tick(make_tick(6, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0));
    // SINGLE edge wins over an interval that has run out.
    send_tick(make_tick(5, 1'b1, 1'b1, 1'b0, 32'd0, 32'd500));
    send_tick(make_tick(5, 1'b1, 1'b1, 1'b1, 32'd10, 32'd600));
    send_tick(make_tick(5, 1'b1, 1'b1, 1'b0, 32'd10, 32'd609));
    send_tick(make_tick(5, 1'b1, 1'b1, 1'b0, 32'd10, 32'd610));

    sim_ms = 32'hFFFF_FC00 + $urandom_range(0, 255);
    for (int i = 0; i < tts_pkg::TaskSpace; i++) begin
      level[i] = 1'b0;
      period[i] = pick_period();
    end
    for (int n = 0; n < NumRandomTicks; n++) begin
      send_tick(next_random_tick());
    end
    in_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Ticks sent: %0d; SINGLE edge triggers: %0d; interval triggers: %0d.",
             sb.ticks, sb.single_hits, sb.interval_hits);
    $display("Random ticks followed a wrapping millisecond clock under random back-pressure.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("task_trigger_scheduler_tb passed");
    end else begin
      $display("task_trigger_scheduler_tb failed");
    end
    $finish;
  end

endmodule

>>> task_trigger_scheduler.f
+incdir+hw/rtl
hw/rtl/tts_pkg.sv
hw/rtl/tts_stream_if.sv
hw/rtl/tts_trigger_eval.sv
hw/rtl/task_trigger_scheduler.sv
tb/sv/task_trigger_scheduler_tb.sv
